### hw/rtl/mm4_pkg.sv
// ----------------------------------------------------------------------------
// mm4_pkg
// shared types and constants for the 4x4 fixed point matrix multiplier
// ----------------------------------------------------------------------------
package mm4_pkg;

    // matrix geometry
    localparam int DIM_LOG  = 2;
    localparam int CELL_LOG = 2 * DIM_LOG;
    localparam int CELLS    = 1 << CELL_LOG;

    // element format, q16.16 signed
    localparam int ELEM_W    = 32;
    localparam int FRAC_BITS = 16;

    // product and exact four term sum
    localparam int PROD_W = 2 * ELEM_W;
    localparam int ACC_W  = PROD_W + DIM_LOG;

    // request commands
    typedef enum logic [1:0] {
        CMD_WRITE_A = 2'd0,
        CMD_WRITE_B = 2'd1,
        CMD_COMPUTE = 2'd2
    } t_cmd;

    // sequencer states
    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_MAC  = 2'd1,
        S_EMIT = 2'd2
    } t_state;

    // sequencer to mac unit
    typedef struct packed {
        logic op_vld;
        logic acc_clr;
    } t_mac_ctrl;

endpackage

### hw/rtl/matrix_multiply_4x4_core.sv
// ----------------------------------------------------------------------------
// matrix_multiply_4x4_core
// 4x4 q16.16 matrix multiplier with one shared multiply-accumulate unit
// ----------------------------------------------------------------------------
// Requests either load one element of operand a or b (ready again straight
// away) or start a compute. A compute emits 16 results in flat
// order, out[r*4+c] = sum_j b[r*4+j]*a[j*4+c], exact 66-bit sum, floor shift
// by the fraction width and saturation to 32 bits, with o_last on the final
// one. All 64 products go through a single 32x32 multiplier: for each element
// the sequencer issues its products, waits for the operand and product
// registers to drain, then emits the result once the output has room. The
// input is not ready until the compute has finished. Unused command codes are
// accepted and dropped. Both operand stores come out of reset as all zeros.
// ----------------------------------------------------------------------------
module matrix_multiply_4x4_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // request channel
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [1:0]                           i_cmd,
    input  logic [mm4_pkg::CELL_LOG-1:0]         i_elem_index,
    input  logic signed [mm4_pkg::ELEM_W-1:0]    i_elem_value,
    // result channel
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [mm4_pkg::CELL_LOG-1:0]         o_out_index,
    output logic signed [mm4_pkg::ELEM_W-1:0]    o_out_value,
    output logic                                 o_last
);
    import mm4_pkg::*;

    // operand stores
    logic signed [ELEM_W-1:0] r_store_a [CELLS];
    logic signed [ELEM_W-1:0] r_store_b [CELLS];

    // sequencer
    t_state                r_state, n_state;
    logic [CELL_LOG-1:0]   r_elem,  n_elem;
    logic [DIM_LOG-1:0]    r_step,  n_step;

    // output register
    logic                     r_out_vld,   n_out_vld;
    logic [CELL_LOG-1:0]      r_out_index, n_out_index;
    logic signed [ELEM_W-1:0] r_out_value, n_out_value;
    logic                     r_out_last,  n_out_last;

    logic                     in_acc;
    logic                     out_free;
    logic                     mac_busy;
    logic signed [ELEM_W-1:0] mac_result;
    logic signed [ELEM_W-1:0] op_a;
    logic signed [ELEM_W-1:0] op_b;
    t_mac_ctrl                mac_ctrl;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign out_free   = !r_out_vld || i_out_ready;

    // a[j][c] and b[r][j] for current element and step
    assign op_a = r_store_a[{r_step, r_elem[DIM_LOG-1:0]}];
    assign op_b = r_store_b[{r_elem[CELL_LOG-1:DIM_LOG], r_step}];

    // element loads
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < CELLS; k++) begin
                r_store_a[k] <= '0;
                r_store_b[k] <= '0;
            end
        end else if (in_acc) begin
            if (i_cmd == CMD_WRITE_A) begin
                r_store_a[i_elem_index] <= i_elem_value;
            end else if (i_cmd == CMD_WRITE_B) begin
                r_store_b[i_elem_index] <= i_elem_value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_elem    <= '0;
            r_step    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_elem    <= n_elem;
            r_step    <= n_step;
            r_out_vld <= n_out_vld;
        end
    end

    // output payload, no reset needed
    always_ff @(posedge i_clk) begin
        r_out_index <= n_out_index;
        r_out_value <= n_out_value;
        r_out_last  <= n_out_last;
    end

    always_comb begin
        n_state          = r_state;
        n_elem           = r_elem;
        n_step           = r_step;
        n_out_vld        = r_out_vld && !i_out_ready;
        n_out_index      = r_out_index;
        n_out_value      = r_out_value;
        n_out_last       = r_out_last;
        mac_ctrl.op_vld  = 1'b0;
        mac_ctrl.acc_clr = 1'b0;
        case (r_state)
            S_IDLE: begin
                // loads are handled in the store block
                if (in_acc && i_cmd == CMD_COMPUTE) begin
                    n_state          = S_MAC;
                    n_elem           = '0;
                    n_step           = '0;
                    mac_ctrl.acc_clr = 1'b1;
                end
            end
            S_MAC: begin
                // one product issued per cycle
                mac_ctrl.op_vld = 1'b1;
                n_step          = r_step + 1'b1;
                if (r_step == {DIM_LOG{1'b1}}) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                // wait for the sum to settle and for room at the output
                if (!mac_busy && out_free) begin
                    n_out_vld   = 1'b1;
                    n_out_index = r_elem;
                    n_out_value = mac_result;
                    n_out_last  = (r_elem == {CELL_LOG{1'b1}});
                    if (r_elem == {CELL_LOG{1'b1}}) begin
                        n_state = S_IDLE;
                    end else begin
                        n_state          = S_MAC;
                        n_elem           = r_elem + 1'b1;
                        n_step           = '0;
                        mac_ctrl.acc_clr = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    mm4_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (mac_ctrl),
        .i_op_a   (op_a),
        .i_op_b   (op_b),
        .o_busy   (mac_busy),
        .o_result (mac_result)
    );

    assign o_out_valid = r_out_vld;
    assign o_out_index = r_out_index;
    assign o_out_value = r_out_value;
    assign o_last      = r_out_last;

    a_compute_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_cmd == CMD_COMPUTE) |=> !o_in_ready)
        else $error("ready stayed high after a compute request");

    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_last) |-> (o_out_index == {CELL_LOG{1'b1}}))
        else $error("last flag on a result other than the final element");

    a_idle_pipe_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !mac_busy)
        else $error("mac pipeline busy while idle");

    a_load_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_cmd != CMD_COMPUTE && !o_out_valid) |=> !o_out_valid)
        else $error("load request produced a result");

endmodule

### hw/rtl/mm4_mac.sv
// ----------------------------------------------------------------------------
// mm4_mac
// shared multiply-accumulate unit with floor shift and saturation
// ----------------------------------------------------------------------------
module mm4_mac (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  mm4_pkg::t_mac_ctrl                   i_ctrl,
    input  logic signed [mm4_pkg::ELEM_W-1:0]    i_op_a,
    input  logic signed [mm4_pkg::ELEM_W-1:0]    i_op_b,
    output logic                                 o_busy,
    output logic signed [mm4_pkg::ELEM_W-1:0]    o_result
);
    import mm4_pkg::*;

    localparam int HI_W = ACC_W - ELEM_W + 1;

    logic                     r_op_vld;
    logic signed [ELEM_W-1:0] r_op_a;
    logic signed [ELEM_W-1:0] r_op_b;
    logic                     r_prod_vld;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;

    logic signed [ACC_W-1:0]  shifted;
    logic [HI_W-1:0]          hi_bits;
    logic                     fits;

    // control pipe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op_vld   <= 1'b0;
            r_prod_vld <= 1'b0;
        end else begin
            r_op_vld   <= i_ctrl.op_vld;
            r_prod_vld <= r_op_vld;
        end
    end

    // operand, product and accumulator registers
    always_ff @(posedge i_clk) begin
        if (i_ctrl.op_vld) begin
            r_op_a <= i_op_a;
            r_op_b <= i_op_b;
        end
        if (r_op_vld) begin
            r_prod <= r_op_a * r_op_b;
        end
        if (i_ctrl.acc_clr) begin
            r_acc <= '0;
        end else if (r_prod_vld) begin
            r_acc <= r_acc + {{DIM_LOG{r_prod[PROD_W-1]}}, r_prod};
        end
    end

    // floor shift then clamp to the signed element range
    always_comb begin
        shifted = r_acc >>> FRAC_BITS;
        hi_bits = shifted[ACC_W-1:ELEM_W-1];
        fits    = (hi_bits == '0) || (hi_bits == '1);
        if (fits) begin
            o_result = shifted[ELEM_W-1:0];
        end else if (r_acc[ACC_W-1]) begin
            o_result = {1'b1, {(ELEM_W-1){1'b0}}};
        end else begin
            o_result = {1'b0, {(ELEM_W-1){1'b1}}};
        end
    end

    assign o_busy = r_op_vld | r_prod_vld;

    a_prod_follows_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.op_vld |=> ##1 r_prod_vld)
        else $error("product stage did not follow operand issue");

    a_no_clear_midway: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.acc_clr |-> !r_prod_vld)
        else $error("accumulator cleared while a product is pending");

endmodule

### tb/matrix_multiply_4x4_core_test.sv
// ----------------------------------------------------------------------------
// matrix_multiply_4x4_core_test
// self-checking regression for the 4x4 q16.16 matrix multiplier
// ----------------------------------------------------------------------------
// Loads both operand stores one element per request and starts computes.
// Every product element that comes back is checked against an independent
// model of the multiplier: exact four-term sum, floor shift and saturation.
// A short table of hand-picked requests comes first. It covers reset
// contents, both saturation limits, floor rounding, the unused command code
// and compute fields that are ignored. Random requests follow in three
// flow-control phases, one of which holds the result side off long enough to
// stall the request side.
// ----------------------------------------------------------------------------
module matrix_multiply_4x4_core_test;
    import mm4_pkg::*;

    // command code with no meaning in the block, must be dropped
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam int RANDOM_PER_PHASE = 83;
    localparam int BACKLOG_CYCLES   = 300;
    localparam int DRAIN_CYCLES     = 50;

    localparam logic signed [ACC_W-1:0] SAT_HI = 66'sd2147483647;
    localparam logic signed [ACC_W-1:0] SAT_LO = -66'sd2147483648;

    // flow-control phases of the random part
    typedef enum logic [1:0] {
        PH_RECV_SLOW = 2'd0,    // sender idles 19 %, receiver 68 %
        PH_SEND_SLOW = 2'd1,    // sender idles 68 %, receiver 19 %
        PH_STEADY    = 2'd2     // no idling, one long receiver hold-off
    } t_phase;

    // one row of the hand-written request table
    typedef struct packed {
        logic [1:0]          cmd;
        logic [CELL_LOG-1:0] idx;
        logic [ELEM_W-1:0]   val;
        logic                pinned;    // element 0 result typed in below
        logic [ELEM_W-1:0]   want0;
    } t_table_row;

    // one product element as it should leave the block
    typedef struct packed {
        logic [CELL_LOG-1:0] index;
        logic [ELEM_W-1:0]   value;
        logic                last;
    } t_product;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_in_valid;
    logic                       o_in_ready;
    logic [1:0]                 i_cmd;
    logic [CELL_LOG-1:0]        i_elem_index;
    logic signed [ELEM_W-1:0]   i_elem_value;
    logic                       o_out_valid;
    logic                       i_out_ready;
    logic [CELL_LOG-1:0]        o_out_index;
    logic signed [ELEM_W-1:0]   o_out_value;
    logic                       o_last;

    // local copies of the two operand stores
    logic signed [ELEM_W-1:0]   mat_a [CELLS];
    logic signed [ELEM_W-1:0]   mat_b [CELLS];

    t_product                   pending_products [$];
    int                         mismatch_count;
    t_phase                     phase;

    // hand-picked requests, element 0 typed in only where it is obvious
    t_table_row directed_rows [21] = '{
        // compute straight after reset, both stores zero
        '{CMD_COMPUTE, 4'd0,  32'h0000_0000, 1'b1, 32'h0000_0000},
        // largest positive times largest positive saturates high
        '{CMD_WRITE_A, 4'd0,  32'h7FFF_FFFF, 1'b0, 32'h0},
        '{CMD_WRITE_B, 4'd0,  32'h7FFF_FFFF, 1'b0, 32'h0},
        '{CMD_COMPUTE, 4'd0,  32'h0000_0000, 1'b1, 32'h7FFF_FFFF},
        // most negative times largest positive saturates low
        '{CMD_WRITE_B, 4'd0,  32'h8000_0000, 1'b0, 32'h0},
        '{CMD_COMPUTE, 4'd0,  32'h0000_0000, 1'b1, 32'h8000_0000},
        // most negative squared saturates high
        '{CMD_WRITE_A, 4'd0,  32'h8000_0000, 1'b0, 32'h0},
        '{CMD_COMPUTE, 4'd0,  32'h0000_0000, 1'b1, 32'h7FFF_FFFF},
        // unused command must leave the stores alone
        '{CMD_UNUSED,  4'd15, 32'hFFFF_FFFF, 1'b0, 32'h0},
        // compute with index and value fields fully set, they are ignored
        '{CMD_COMPUTE, 4'd15, 32'hFFFF_FFFF, 1'b1, 32'h7FFF_FFFF},
        // one times one
        '{CMD_WRITE_A, 4'd0,  32'h0001_0000, 1'b0, 32'h0},
        '{CMD_WRITE_B, 4'd0,  32'h0001_0000, 1'b0, 32'h0},
        '{CMD_COMPUTE, 4'd0,  32'h0000_0000, 1'b1, 32'h0001_0000},
        // minus one lsb times a half floors to minus one lsb
        '{CMD_WRITE_A, 4'd0,  32'hFFFF_FFFF, 1'b0, 32'h0},
        '{CMD_WRITE_B, 4'd0,  32'h0000_8000, 1'b0, 32'h0},
        '{CMD_COMPUTE, 4'd0,  32'h0000_0000, 1'b1, 32'hFFFF_FFFF},
        // top corner entries and a mixed-sign sum into element 0
        '{CMD_WRITE_A, 4'd15, 32'h0002_0000, 1'b0, 32'h0},
        '{CMD_WRITE_B, 4'd15, 32'hFFFE_0000, 1'b0, 32'h0},
        '{CMD_WRITE_A, 4'd4,  32'h7FFF_FFFF, 1'b0, 32'h0},
        '{CMD_WRITE_B, 4'd1,  32'h8000_0000, 1'b0, 32'h0},
        '{CMD_COMPUTE, 4'd7,  32'h5A5A_A5A5, 1'b0, 32'h0}
    };

    matrix_multiply_4x4_core u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_cmd        (i_cmd),
        .i_elem_index (i_elem_index),
        .i_elem_value (i_elem_value),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_index  (o_out_index),
        .o_out_value  (o_out_value),
        .o_last       (o_last)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // one product element: exact 66-bit sum, floor shift, saturate
    function automatic logic [ELEM_W-1:0] product_element(input int row, input int col);
        logic signed [PROD_W-1:0] term;
        logic signed [ACC_W-1:0]  acc;
        logic signed [ACC_W-1:0]  scaled;
        acc = '0;
        for (int j = 0; j < 4; j++) begin
            term = mat_b[row*4 + j] * mat_a[j*4 + col];
            acc  = acc + term;
        end
        scaled = acc >>> FRAC_BITS;
        if (scaled > SAT_HI)
            return 32'h7FFF_FFFF;
        if (scaled < SAT_LO)
            return 32'h8000_0000;
        return scaled[ELEM_W-1:0];
    endfunction

    // element values: limits, plain random, and small values that rarely saturate
    function automatic logic [ELEM_W-1:0] pick_element_value();
        logic [ELEM_W-1:0] v;
        case ($urandom_range(0, 3))
            0: begin
                case ($urandom_range(0, 5))
                    0:       v = 32'h7FFF_FFFF;
                    1:       v = 32'h8000_0000;
                    2:       v = 32'h0000_0000;
                    3:       v = 32'hFFFF_FFFF;
                    4:       v = 32'h0001_0000;
                    default: v = 32'hFFFF_0000;
                endcase
            end
            1:       v = $urandom();
            default: v = $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
        endcase
        return v;
    endfunction

    // offer one request, wait for the handshake, then update the store copies
    task automatic send_request(input logic [1:0] cmd, input logic [CELL_LOG-1:0] idx,
                                input logic [ELEM_W-1:0] val, input logic pinned,
                                input logic [ELEM_W-1:0] want0);
        int       idle_pct;
        t_product entry;
        case (phase)
            PH_RECV_SLOW: idle_pct = 19;
            PH_SEND_SLOW: idle_pct = 68;
            default:      idle_pct = 0;
        endcase
        while ($urandom_range(0, 99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_cmd        <= cmd;
        i_elem_index <= idx;
        i_elem_value <= val;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        // request taken at this edge
        case (cmd)
            CMD_WRITE_A: mat_a[idx] = val;
            CMD_WRITE_B: mat_b[idx] = val;
            CMD_COMPUTE: begin
                for (int k = 0; k < CELLS; k++) begin
                    entry.index = k[CELL_LOG-1:0];
                    entry.value = product_element(k / 4, k % 4);
                    entry.last  = (k == CELLS - 1);
                    if (k == 0 && pinned)
                        entry.value = want0;
                    pending_products.push_back(entry);
                end
            end
            default: ;  // dropped by the block
        endcase
        @(negedge i_clk);
    endtask

    // random requests for one phase, unused commands not counted
    task automatic run_random_phase(input t_phase ph);
        int         sent;
        int         roll;
        logic [1:0] cmd;
        phase = ph;
        sent  = 0;
        while (sent < RANDOM_PER_PHASE) begin
            roll = $urandom_range(0, 99);
            if (roll < 42)
                cmd = CMD_WRITE_A;
            else if (roll < 84)
                cmd = CMD_WRITE_B;
            else if (roll < 95)
                cmd = CMD_COMPUTE;
            else
                cmd = CMD_UNUSED;
            // open the steady phase with a compute so the hold-off backs it up
            if (ph == PH_STEADY && sent == 0)
                cmd = CMD_COMPUTE;
            send_request(cmd, CELL_LOG'($urandom_range(0, CELLS - 1)), pick_element_value(),
                         1'b0, 32'h0);
            if (cmd != CMD_UNUSED)
                sent++;
        end
    endtask

    // result side: random stalls, plus one long hold-off in the steady phase
    initial begin : result_sink
        int  idle_pct;
        bit  backlog_done;
        backlog_done = 1'b0;
        i_out_ready  = 1'b0;
        forever begin
            @(negedge i_clk);
            if (phase == PH_STEADY && !backlog_done) begin
                i_out_ready <= 1'b0;
                for (int n = 0; n < BACKLOG_CYCLES; n++)
                    @(negedge i_clk);
                backlog_done = 1'b1;
            end else begin
                case (phase)
                    PH_RECV_SLOW: idle_pct = 68;
                    PH_SEND_SLOW: idle_pct = 19;
                    default:      idle_pct = 0;
                endcase
                i_out_ready <= ($urandom_range(0, 99) >= idle_pct);
            end
        end
    end

    // result checker, oldest expectation first
    always @(posedge i_clk) begin : check_results
        t_product want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_products.size() == 0) begin
                $display("%0t unexpected result: index %0d value %h last %b",
                         $time, o_out_index, o_out_value, o_last);
                mismatch_count++;
            end else begin
                want = pending_products.pop_front();
                if (o_out_index !== want.index) begin
                    $display("%0t index mismatch: expected %0d, actual %0d",
                             $time, want.index, o_out_index);
                    mismatch_count++;
                end
                if (o_out_value !== want.value) begin
                    $display("%0t value mismatch at index %0d: expected %h, actual %h",
                             $time, want.index, want.value, o_out_value);
                    mismatch_count++;
                end
                if (o_last !== want.last) begin
                    $display("%0t last flag mismatch at index %0d: expected %b, actual %b",
                             $time, want.index, want.last, o_last);
                    mismatch_count++;
                end
            end
        end
    end

    // stimulus and verdict
    initial begin : stimulus
        mismatch_count = 0;
        phase          = PH_RECV_SLOW;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_cmd          = CMD_WRITE_A;
        i_elem_index   = '0;
        i_elem_value   = '0;
        for (int k = 0; k < CELLS; k++) begin
            mat_a[k] = '0;
            mat_b[k] = '0;
        end

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int r = 0; r < $size(directed_rows); r++)
            send_request(directed_rows[r].cmd, directed_rows[r].idx, directed_rows[r].val,
                         directed_rows[r].pinned, directed_rows[r].want0);

        run_random_phase(PH_RECV_SLOW);
        run_random_phase(PH_SEND_SLOW);
        run_random_phase(PH_STEADY);
        i_in_valid <= 1'b0;

        // let every outstanding product element drain, then a short tail
        while (pending_products.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("matrix_multiply_4x4_core regression: pass");
        else
            $display("matrix_multiply_4x4_core regression: fail");
        $finish;
    end

    // hang guard, well above the slowest legal run
    initial begin : watchdog
        #5_000_000;
        $display("matrix_multiply_4x4_core regression: fail");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/mm4_pkg.sv
hw/rtl/mm4_mac.sv
hw/rtl/matrix_multiply_4x4_core.sv
tb/matrix_multiply_4x4_core_test.sv
